/* rtl/core/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by the core top level.
package wsd_pkg;

    // Per-connection deframing stage
    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_LEN  = 3'd1,
        ST_EXT  = 3'd2,
        ST_KEY  = 3'd3,
        ST_PAY  = 3'd4
    } t_stage;

    // Result event codes
    typedef enum logic [2:0] {
        EV_BYTE  = 3'd0,
        EV_EMPTY = 3'd1,
        EV_OVER  = 3'd2,
        EV_CTRL  = 3'd3,
        EV_RSV   = 3'd4
    } t_event;

    localparam logic [7:0]  RSV_MASK        = 8'b0111_0000;
    localparam logic [7:0]  OPC_MASK        = 8'b0000_1111;
    localparam logic [7:0]  LEN_MASK        = 8'b0111_1111;
    localparam logic [7:0]  FIN_MASK        = 8'b1000_0000;
    localparam logic [6:0]  LEN_EXT16       = 7'd126;
    localparam logic [6:0]  LEN_EXT64       = 7'd127;
    localparam logic [63:0] CTRL_MAX_LEN    = 64'd125;
    localparam logic [3:0]  CTRL_OPC        = 4'h8;
    localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;
    localparam logic [3:0]  EXT16_BYTES     = 4'd2;
    localparam logic [3:0]  EXT64_BYTES     = 4'd8;
    localparam logic [3:0]  KEY_BYTES       = 4'd4;

    // One connection's state word in the context memory.
    // remain holds the length while it is assembled, then the bytes still due.
    typedef struct packed {
        t_stage      stage;
        logic [3:0]  hdr_left;
        logic [3:0]  opcode;
        logic        fin;
        logic        masked;
        logic [31:0] key;
        logic [63:0] remain;
        logic [1:0]  key_idx;
    } t_entry;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  data;
        logic [3:0]  opcode;
        logic        fin;
        logic        last;
    } t_result;

endpackage

/* rtl/core/wsd_in_if.sv */
// Input byte channel of the deframer: valid/ready plus one received byte.
// No dependencies.
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] conn_id;
    logic [7:0] data_byte;
    logic       packet_start;

    modport source (output valid, conn_id, data_byte, packet_start, input ready);
    modport sink   (input valid, conn_id, data_byte, packet_start, output ready);
endinterface

/* rtl/core/wsd_out_if.sv */
// Result channel of the deframer: valid/ready plus one result item.
// No dependencies.
interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] out_conn;
    logic [2:0] event_res;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic       is_control;
    logic       frame_last;

    modport source (output valid, out_conn, event_res, payload_byte, frame_opcode,
                    frame_fin, is_control, frame_last, input ready);
    modport sink   (input valid, out_conn, event_res, payload_byte, frame_opcode,
                    frame_fin, is_control, frame_last, output ready);
endinterface

/* rtl/core/wsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/websocket_frame_deframer_top.sv */
// WebSocket frame deframer core: per-connection context in one RAM, read-modify-write.
// Depends on wsd_pkg, wsd_in_if, wsd_out_if and wsd_ram.
//
//  Port          Dir  Kind          Carries
//  i_in_ch       in   valid/ready   conn_id, data_byte, packet_start
//  o_out_ch      out  valid/ready   out_conn, event_res, payload_byte, frame_opcode,
//                                   frame_fin, is_control, frame_last
//  i_cfg_wr_*    in   write strobe  max_frame_size
//
// One byte per cycle. The context RAM is read at the accept edge, the entry is updated
// in the update stage and written back when that stage advances; a one-entry bypass
// covers back-to-back bytes of one connection. A result is loaded into the output
// register when its byte leaves the update stage, and transfers from there.
// After reset a clearing pass writes a zero entry for every connection, setting it idle;
// input is held off meanwhile. Afterwards, input stalls only when a byte that makes a
// result meets a full output register that is not being drained.
module websocket_frame_deframer_top
    import wsd_pkg::*;
#(
    parameter int CONNECTIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    wsd_in_if.sink      i_in_ch,
    wsd_out_if.source   o_out_ch
);

    localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int EW = $bits(t_entry);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CONNECTIONS - 1);

    logic [31:0]   r_max_frame;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          r_s1_valid;
    logic [3:0]    r_s1_conn;
    logic [7:0]    r_s1_byte;
    logic          r_s1_start;

    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    t_entry        r_fwd_entry;

    logic          r_out_valid;
    logic [3:0]    r_out_conn;
    t_result       r_out;

    logic [31:0]   in_conn_ext;
    logic          in_range;
    logic [AW-1:0] in_addr;
    logic          in_ready;
    logic          in_acc;
    logic [31:0]   s1_conn_ext;
    logic [AW-1:0] s1_addr;
    logic          s1_go;

    logic [EW-1:0] ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;

    t_entry        cur;
    t_entry        n_entry;
    t_stage        eff_stage;
    t_stage        ld_stage;
    logic [6:0]    len7;
    logic          is_ext_code;
    logic [3:0]    hdr_dec;
    logic [63:0]   ext_len;
    logic [63:0]   chk_len;
    logic          chk_masked;
    logic          too_big;
    logic          ctrl_long;
    logic          len_zero;
    logic          remain_zero;
    logic          pay_last;
    logic [7:0]    key_byte;
    logic          res_valid;
    t_result       res;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= MAX_FRAME_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_frame <= i_cfg_wr_data;
        end
    end

    // ---------------- clearing pass ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------- input side ----------------
    assign in_conn_ext = 32'(i_in_ch.conn_id);
    assign in_range    = in_conn_ext < 32'(CONNECTIONS);
    assign in_addr     = in_conn_ext[AW-1:0];
    assign s1_conn_ext = 32'(r_s1_conn);
    assign s1_addr     = s1_conn_ext[AW-1:0];

    assign s1_go    = r_s1_valid && (!res_valid || !r_out_valid || o_out_ch.ready);
    assign in_ready = !r_clr_busy && (!r_s1_valid || s1_go);
    assign in_acc   = i_in_ch.valid && in_ready;
    assign i_in_ch.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            // out-of-range connections are taken and dropped here
            r_s1_valid <= in_acc && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_conn  <= i_in_ch.conn_id;
            r_s1_byte  <= i_in_ch.data_byte;
            r_s1_start <= i_in_ch.packet_start;
        end
    end

    // ---------------- context memory ----------------
    assign ram_we    = r_clr_busy || s1_go;
    assign ram_waddr = r_clr_busy ? r_clr_addr : s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : n_entry;

    wsd_ram #(
        .WIDTH (EW),
        .DEPTH (CONNECTIONS)
    ) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // Last write-back; covers the read that coincides with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (s1_go) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_fwd_addr  <= s1_addr;
            r_fwd_entry <= n_entry;
        end
    end

    assign cur = (r_fwd_valid && r_fwd_addr == s1_addr) ? r_fwd_entry : t_entry'(ram_rdata);

    // ---------------- decode ----------------
    always_comb begin
        eff_stage = cur.stage;
        // packet start during the header restarts parsing
        if (r_s1_start && (cur.stage == ST_LEN || cur.stage == ST_EXT ||
                           cur.stage == ST_KEY)) begin
            eff_stage = ST_IDLE;
        end
    end

    assign len7        = r_s1_byte[6:0] & LEN_MASK[6:0];
    assign is_ext_code = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
    assign hdr_dec     = cur.hdr_left - 4'd1;
    assign ext_len     = {cur.remain[55:0], r_s1_byte};
    assign chk_len     = (eff_stage == ST_LEN) ? 64'(len7) : ext_len;
    assign chk_masked  = (eff_stage == ST_LEN) ? r_s1_byte[7] : cur.masked;
    assign too_big     = chk_len > 64'(r_max_frame);
    assign ctrl_long   = (cur.opcode >= CTRL_OPC) && (chk_len > CTRL_MAX_LEN);
    assign len_zero    = chk_len == 64'd0;
    assign remain_zero = cur.remain == 64'd0;
    assign pay_last    = cur.remain[63:1] == 63'd0;

    always_comb begin
        if (too_big || ctrl_long) begin
            ld_stage = ST_IDLE;
        end else if (chk_masked) begin
            ld_stage = ST_KEY;
        end else if (len_zero) begin
            ld_stage = ST_IDLE;
        end else begin
            ld_stage = ST_PAY;
        end
    end

    always_comb begin
        case (cur.key_idx)
            2'd0:    key_byte = cur.key[31:24];
            2'd1:    key_byte = cur.key[23:16];
            2'd2:    key_byte = cur.key[15:8];
            2'd3:    key_byte = cur.key[7:0];
            default: key_byte = cur.key[31:24];
        endcase
    end

    // ---------------- next context ----------------
    always_comb begin
        n_entry = cur;
        case (eff_stage)
            ST_IDLE: begin
                if (r_s1_start && (r_s1_byte & RSV_MASK) == 8'd0) begin
                    n_entry.opcode = 4'(r_s1_byte & OPC_MASK);
                    n_entry.fin    = (r_s1_byte & FIN_MASK) != 8'd0;
                    n_entry.stage  = ST_LEN;
                end else begin
                    n_entry.stage  = ST_IDLE;
                end
            end
            ST_LEN: begin
                n_entry.masked = r_s1_byte[7];
                if (is_ext_code) begin
                    n_entry.hdr_left = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    n_entry.remain   = 64'd0;
                    n_entry.stage    = ST_EXT;
                end else begin
                    n_entry.remain   = chk_len;
                    n_entry.key      = '0;
                    n_entry.hdr_left = KEY_BYTES;
                    n_entry.key_idx  = '0;
                    n_entry.stage    = ld_stage;
                end
            end
            ST_EXT: begin
                n_entry.remain   = ext_len;
                n_entry.hdr_left = hdr_dec;
                if (hdr_dec == 4'd0) begin
                    n_entry.key      = '0;
                    n_entry.hdr_left = KEY_BYTES;
                    n_entry.key_idx  = '0;
                    n_entry.stage    = ld_stage;
                end
            end
            ST_KEY: begin
                n_entry.key      = {cur.key[23:0], r_s1_byte};
                n_entry.hdr_left = hdr_dec;
                if (hdr_dec == 4'd0) begin
                    n_entry.key_idx = '0;
                    n_entry.stage   = remain_zero ? ST_IDLE : ST_PAY;
                end
            end
            ST_PAY: begin
                n_entry.key_idx = cur.key_idx + 2'd1;
                n_entry.remain  = cur.remain - 64'd1;
                if (pay_last) begin
                    n_entry.stage = ST_IDLE;
                end
            end
            default: begin
                n_entry.stage = ST_IDLE;
            end
        endcase
    end

    // ---------------- result ----------------
    always_comb begin
        res_valid  = 1'b0;
        res.ev     = EV_BYTE;
        res.data   = 8'd0;
        res.opcode = cur.opcode;
        res.fin    = cur.fin;
        res.last   = 1'b0;
        case (eff_stage)
            ST_IDLE: begin
                if (r_s1_start && (r_s1_byte & RSV_MASK) != 8'd0) begin
                    res_valid  = 1'b1;
                    res.ev     = EV_RSV;
                    res.opcode = 4'(r_s1_byte & OPC_MASK);
                    res.fin    = (r_s1_byte & FIN_MASK) != 8'd0;
                end
            end
            ST_LEN, ST_EXT: begin
                if ((eff_stage == ST_LEN && !is_ext_code) ||
                    (eff_stage == ST_EXT && hdr_dec == 4'd0)) begin
                    if (too_big) begin
                        res_valid = 1'b1;
                        res.ev    = EV_OVER;
                    end else if (ctrl_long) begin
                        res_valid = 1'b1;
                        res.ev    = EV_CTRL;
                    end else if (!chk_masked && len_zero) begin
                        res_valid = 1'b1;
                        res.ev    = EV_EMPTY;
                        res.last  = 1'b1;
                    end
                end
            end
            ST_KEY: begin
                if (hdr_dec == 4'd0 && remain_zero) begin
                    res_valid = 1'b1;
                    res.ev    = EV_EMPTY;
                    res.last  = 1'b1;
                end
            end
            ST_PAY: begin
                res_valid = 1'b1;
                res.ev    = EV_BYTE;
                res.data  = r_s1_byte ^ (cur.masked ? key_byte : 8'd0);
                res.last  = pay_last;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && res_valid) begin
            r_out_conn <= r_s1_conn;
            r_out      <= res;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.out_conn     = r_out_conn;
    assign o_out_ch.event_res    = r_out.ev;
    assign o_out_ch.payload_byte = r_out.data;
    assign o_out_ch.frame_opcode = r_out.opcode;
    assign o_out_ch.frame_fin    = r_out.fin;
    assign o_out_ch.is_control   = r_out.opcode >= CTRL_OPC;
    assign o_out_ch.frame_last   = r_out.last;

    // ---------------- assertions ----------------
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !in_acc)
        else $error("byte taken during clearing pass");

    a_stall_only_on_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |-> (res_valid && r_out_valid && !o_out_ch.ready))
        else $error("update stage held without a full output register");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && res_valid && res.last) |-> (n_entry.stage == ST_IDLE))
        else $error("frame end did not return connection to idle");

    a_bypass_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> (r_fwd_valid && r_fwd_addr == $past(s1_addr)))
        else $error("bypass entry does not match last write-back");

endmodule

/* bench/websocket_frame_deframer_top_tb.sv */
// Testbench for websocket_frame_deframer_top: byte-level stimulus on 16 connections,
// an in-bench deframer model and a scoreboard that checks every result transfer.
// Depends on wsd_pkg, wsd_in_if, wsd_out_if and the RTL under rtl/core.
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb
    import wsd_pkg::*;
();

    localparam int NUM_CONN     = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 300;

    // WebSocket opcodes used by the stimulus
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    typedef struct packed {
        logic [3:0] conn;
        t_event     ev;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       fin;
        logic       ctrl;
        logic       last;
    } t_deframe_res;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       stray;
    } t_link_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    wsd_in_if  in_ch ();
    wsd_out_if out_ch ();

    websocket_frame_deframer_top #(
        .CONNECTIONS (NUM_CONN)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_ch       (in_ch),
        .o_out_ch      (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Per-connection deframing context of the model
    t_stage      ctx_stage    [NUM_CONN];
    logic [3:0]  ctx_hdr_left [NUM_CONN];
    logic [3:0]  ctx_opcode   [NUM_CONN];
    logic        ctx_fin      [NUM_CONN];
    logic        ctx_masked   [NUM_CONN];
    logic [31:0] ctx_key      [NUM_CONN];
    logic [63:0] ctx_len      [NUM_CONN];
    logic [63:0] ctx_rcvd     [NUM_CONN];
    logic [31:0] max_frame;

    t_deframe_res frame_results_q [$];
    t_link_byte   pend_bytes [NUM_CONN][$];

    int mismatch_cnt  = 0;
    bit in_valid_held = 1'b0;
    bit tx_burst      = 1'b0;
    bit rx_burst      = 1'b0;
    bit hold_request  = 1'b0;

    function automatic t_deframe_res make_res(logic [3:0] c, t_event ev, logic [7:0] d,
                                              logic [3:0] op, logic fin, logic last);
        t_deframe_res r;
        r.conn   = c;
        r.ev     = ev;
        r.data   = d;
        r.opcode = op;
        r.fin    = fin;
        r.ctrl   = (op >= CTRL_OPC);
        r.last   = last;
        return r;
    endfunction

    function automatic void reset_context();
        for (int i = 0; i < NUM_CONN; i++) begin
            ctx_stage[i]    = ST_IDLE;
            ctx_hdr_left[i] = '0;
            ctx_opcode[i]   = '0;
            ctx_fin[i]      = 1'b0;
            ctx_masked[i]   = 1'b0;
            ctx_key[i]      = '0;
            ctx_len[i]      = '0;
            ctx_rcvd[i]     = '0;
        end
        max_frame = MAX_FRAME_RESET;
    endfunction

    function automatic void finish_header(int c, output bit has, output t_deframe_res r);
        has = 1'b0;
        r   = '0;
        if (ctx_len[c] == 64'd0) begin
            ctx_stage[c] = ST_IDLE;
            has = 1'b1;
            r = make_res(4'(c), EV_EMPTY, 8'h00, ctx_opcode[c], ctx_fin[c], 1'b1);
        end else begin
            ctx_rcvd[c]  = 64'd0;
            ctx_stage[c] = ST_PAY;
        end
    endfunction

    function automatic void finish_length(int c, output bit has, output t_deframe_res r);
        has = 1'b0;
        r   = '0;
        // size limit wins over the control-frame limit
        if (ctx_len[c] > {32'd0, max_frame}) begin
            ctx_stage[c] = ST_IDLE;
            has = 1'b1;
            r = make_res(4'(c), EV_OVER, 8'h00, ctx_opcode[c], ctx_fin[c], 1'b0);
        end else if (ctx_opcode[c] >= CTRL_OPC && ctx_len[c] > CTRL_MAX_LEN) begin
            ctx_stage[c] = ST_IDLE;
            has = 1'b1;
            r = make_res(4'(c), EV_CTRL, 8'h00, ctx_opcode[c], ctx_fin[c], 1'b0);
        end else if (ctx_masked[c]) begin
            ctx_key[c]      = '0;
            ctx_hdr_left[c] = KEY_BYTES;
            ctx_stage[c]    = ST_KEY;
        end else begin
            finish_header(c, has, r);
        end
    endfunction

    // Advance one connection's context by one received byte.
    function automatic void deframe_byte(logic [3:0] cid, logic [7:0] b, logic s,
                                         output bit has, output t_deframe_res r);
        int     c;
        int     sh;
        t_stage st;
        logic [7:0] key_byte;
        c   = int'(cid);
        has = 1'b0;
        r   = '0;
        st  = ctx_stage[c];
        // a new packet during the header restarts parsing
        if (s && (st == ST_LEN || st == ST_EXT || st == ST_KEY))
            st = ST_IDLE;
        case (st)
            ST_IDLE: begin
                ctx_stage[c] = ST_IDLE;
                if (s) begin
                    if ((b & RSV_MASK) != 8'h00) begin
                        has = 1'b1;
                        r = make_res(cid, EV_RSV, 8'h00, b[3:0], b[7], 1'b0);
                    end else begin
                        ctx_opcode[c] = b[3:0];
                        ctx_fin[c]    = b[7];
                        ctx_stage[c]  = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                ctx_masked[c] = b[7];
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                    ctx_hdr_left[c] = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    ctx_len[c]      = '0;
                    ctx_stage[c]    = ST_EXT;
                end else begin
                    ctx_len[c] = 64'(b & LEN_MASK);
                    finish_length(c, has, r);
                end
            end
            ST_EXT: begin
                ctx_len[c]      = {ctx_len[c][55:0], b};
                ctx_hdr_left[c] = ctx_hdr_left[c] - 4'd1;
                if (ctx_hdr_left[c] == 4'd0)
                    finish_length(c, has, r);
            end
            ST_KEY: begin
                ctx_key[c]      = {ctx_key[c][23:0], b};
                ctx_hdr_left[c] = ctx_hdr_left[c] - 4'd1;
                if (ctx_hdr_left[c] == 4'd0)
                    finish_header(c, has, r);
            end
            ST_PAY: begin
                sh = (3 - int'(ctx_rcvd[c][1:0])) * 8;
                key_byte = ctx_masked[c] ? 8'(ctx_key[c] >> sh) : 8'h00;
                ctx_rcvd[c] = ctx_rcvd[c] + 64'd1;
                if (ctx_rcvd[c] >= ctx_len[c])
                    ctx_stage[c] = ST_IDLE;
                has = 1'b1;
                r = make_res(cid, EV_BYTE, b ^ key_byte, ctx_opcode[c], ctx_fin[c],
                             ctx_rcvd[c] >= ctx_len[c]);
            end
            default: ctx_stage[c] = ST_IDLE;
        endcase
    endfunction

    function automatic logic [7:0] hdr0(logic fin, logic [3:0] op);
        return {fin, 3'b000, op};
    endfunction

    function automatic t_link_byte link_byte(logic [7:0] d, logic s, logic stray);
        t_link_byte lb;
        lb.data  = d;
        lb.start = s;
        lb.stray = stray;
        return lb;
    endfunction

    // Queue the next piece of traffic for one connection: mostly whole frames,
    // some stray bytes, reserved-bit headers and truncated headers.
    function automatic void plan_traffic(int c);
        int          kind;
        int          sel;
        int          ext_n;
        int          cut;
        logic [3:0]  op;
        logic        fin;
        logic        masked;
        logic        accepted;
        logic [7:0]  rsv;
        logic [6:0]  len7;
        logic [31:0] key;
        logic [63:0] len;
        t_link_byte  hdr [$];
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 3))
                pend_bytes[c].push_back(link_byte(8'($urandom), 1'b0, 1'b1));
            return;
        end
        if (kind < 12) begin
            rsv = 8'($urandom);
            rsv[6:4] = 3'($urandom_range(1, 7));
            pend_bytes[c].push_back(link_byte(rsv, 1'b1, 1'b0));
            return;
        end
        case ($urandom_range(0, 7))
            0: op = OP_CONT;
            1: op = OP_TEXT;
            2: op = OP_BIN;
            3: op = OP_CLOSE;
            4: op = OP_PING;
            5: op = OP_PONG;
            default: op = 4'($urandom);
        endcase
        fin    = 1'($urandom);
        masked = 1'($urandom);
        sel    = $urandom_range(0, 99);
        ext_n  = 0;
        if (sel < 55) begin
            len = 64'($urandom_range(0, 12));
        end else if (sel < 70) begin
            len = 64'($urandom_range(0, 125));
        end else if (sel < 85) begin
            len = 64'($urandom_range(0, 300));
            ext_n = 2;
        end else if (sel < 95) begin
            len = 64'($urandom_range(0, 30));
            ext_n = 8;
        end else begin
            // beyond any 32-bit limit, never followed by payload
            len = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
            ext_n = 8;
        end
        len7 = (ext_n == 2) ? LEN_EXT16 : (ext_n == 8) ? LEN_EXT64 : len[6:0];
        hdr.push_back(link_byte(hdr0(fin, op), 1'b1, 1'b0));
        hdr.push_back(link_byte({masked, len7}, 1'b0, 1'b0));
        for (int i = ext_n - 1; i >= 0; i--)
            hdr.push_back(link_byte(len[8*i +: 8], 1'b0, 1'b0));
        accepted = (len <= {32'd0, max_frame}) && !(op >= CTRL_OPC && len > CTRL_MAX_LEN);
        if (masked && accepted) begin
            key = $urandom;
            for (int i = 3; i >= 0; i--)
                hdr.push_back(link_byte(key[8*i +: 8], 1'b0, 1'b0));
        end
        if (kind < 20) begin
            cut = $urandom_range(1, hdr.size() - 1);
            repeat (cut)
                pend_bytes[c].push_back(hdr.pop_front());
            return;
        end
        while (hdr.size() != 0)
            pend_bytes[c].push_back(hdr.pop_front());
        if (accepted) begin
            // occasional packet boundary inside the payload
            for (longint i = 0; i < longint'(len); i++)
                pend_bytes[c].push_back(link_byte(8'($urandom),
                                                  $urandom_range(0, 19) == 0, 1'b0));
        end
    endfunction

    task automatic release_input();
        if (in_valid_held)
            in_ch.valid <= 1'b0;
        in_valid_held = 1'b0;
    endtask

    task automatic send_byte(input logic [3:0] c, input logic [7:0] b, input logic s);
        int           gap;
        bit           has;
        t_deframe_res r;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            release_input();
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.conn_id      <= c;
        in_ch.data_byte    <= b;
        in_ch.packet_start <= s;
        in_valid_held = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        deframe_byte(c, b, s, has, r);
        if (has)
            frame_results_q.push_back(r);
    endtask

    task automatic set_max_frame_size(input logic [31:0] v);
        release_input();
        while (frame_results_q.size() != 0) @(posedge i_clk);
        // header bytes make no result and may still be in the pipeline
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        max_frame = v;
    endtask

    // Bytes already planned count against the budget, so the run ends near n_items.
    task automatic run_random_traffic(input int n_items);
        int         sent;
        int         steps;
        int         c;
        int         queued;
        t_link_byte lb;
        sent  = 0;
        steps = 0;
        forever begin
            queued = 0;
            for (int i = 0; i < NUM_CONN; i++)
                queued += pend_bytes[i].size();
            if (queued == 0 && sent >= n_items)
                break;
            c = $urandom_range(0, NUM_CONN - 1);
            if (pend_bytes[c].size() == 0) begin
                // budget spent: only finish what is already planned
                if (sent + queued >= n_items)
                    continue;
                plan_traffic(c);
            end
            if (steps % 64 == 0) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            steps++;
            lb = pend_bytes[c].pop_front();
            send_byte(4'(c), lb.data, lb.start);
            if (!lb.stray)
                sent++;
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    task automatic test_directed_cases();
        send_byte(4'd3, 8'hA5, 1'b0);                    // idle, no packet start: dropped
        send_byte(4'd1, 8'hF1, 1'b1);                    // reserved bits
        send_byte(4'd14, 8'hFF, 1'b1);
        send_byte(4'd14, 8'h70, 1'b1);
        send_byte(4'd2, hdr0(1'b1, OP_PING), 1'b1);      // empty control frame
        send_byte(4'd2, 8'h00, 1'b0);
        send_byte(4'd15, hdr0(1'b1, OP_TEXT), 1'b1);     // masked, three bytes
        send_byte(4'd15, {1'b1, 7'd3}, 1'b0);
        send_byte(4'd15, 8'h12, 1'b0);
        send_byte(4'd15, 8'h34, 1'b0);
        send_byte(4'd15, 8'h56, 1'b0);
        send_byte(4'd15, 8'h78, 1'b0);
        send_byte(4'd15, 8'h00, 1'b0);
        send_byte(4'd15, 8'hFF, 1'b0);
        send_byte(4'd15, 8'h5A, 1'b0);
        send_byte(4'd0, hdr0(1'b0, OP_TEXT), 1'b1);      // header cut short by a new packet
        send_byte(4'd0, hdr0(1'b1, OP_PONG), 1'b1);
        send_byte(4'd0, 8'h00, 1'b0);
        send_byte(4'd5, hdr0(1'b1, OP_CLOSE), 1'b1);     // control frame of 126 bytes
        send_byte(4'd5, {1'b0, LEN_EXT16}, 1'b0);
        send_byte(4'd5, 8'h00, 1'b0);
        send_byte(4'd5, 8'd126, 1'b0);
        send_byte(4'd7, hdr0(1'b0, OP_BIN), 1'b1);       // continuation packet mid-payload
        send_byte(4'd7, 8'h02, 1'b0);
        send_byte(4'd7, 8'h11, 1'b0);
        send_byte(4'd7, 8'h22, 1'b1);
    endtask

    // Sink holds off while a long frame streams in back to back.
    task automatic test_backpressure();
        hold_request = 1'b1;
        tx_burst     = 1'b1;
        send_byte(4'd9, hdr0(1'b1, OP_BIN), 1'b1);
        send_byte(4'd9, {1'b0, LEN_EXT16}, 1'b0);
        send_byte(4'd9, 8'h00, 1'b0);
        send_byte(4'd9, 8'd200, 1'b0);
        repeat (200) send_byte(4'd9, 8'($urandom), 1'b0);
        tx_burst = 1'b0;
    endtask

    task automatic test_zero_limit();
        set_max_frame_size(32'd0);
        send_byte(4'd4, hdr0(1'b1, OP_BIN), 1'b1);
        send_byte(4'd4, {1'b0, 7'd1}, 1'b0);
        send_byte(4'd4, hdr0(1'b1, OP_CLOSE), 1'b1);
        send_byte(4'd4, 8'h00, 1'b0);
        run_random_traffic(200);
    endtask

    task automatic test_full_limit();
        set_max_frame_size(32'hFFFF_FFFF);
        // 2^32 is one past the largest limit
        send_byte(4'd6, hdr0(1'b0, OP_TEXT), 1'b1);
        send_byte(4'd6, {1'b1, LEN_EXT64}, 1'b0);
        send_byte(4'd6, 8'h00, 1'b0);
        send_byte(4'd6, 8'h00, 1'b0);
        send_byte(4'd6, 8'h00, 1'b0);
        send_byte(4'd6, 8'h01, 1'b0);
        repeat (4) send_byte(4'd6, 8'h00, 1'b0);
        send_byte(4'd11, hdr0(1'b1, OP_TEXT), 1'b1);
        send_byte(4'd11, {1'b1, LEN_EXT64}, 1'b0);
        repeat (7) send_byte(4'd11, 8'h00, 1'b0);
        send_byte(4'd11, 8'd5, 1'b0);
        repeat (4) send_byte(4'd11, 8'($urandom), 1'b0);
        repeat (5) send_byte(4'd11, 8'($urandom), 1'b0);
        run_random_traffic(400);
    endtask

    task automatic test_mid_limit();
        set_max_frame_size(32'd100);
        send_byte(4'd8, hdr0(1'b1, OP_BIN), 1'b1);
        send_byte(4'd8, {1'b0, 7'd100}, 1'b0);
        repeat (100) send_byte(4'd8, 8'($urandom), 1'b0);
        send_byte(4'd8, hdr0(1'b1, OP_BIN), 1'b1);
        send_byte(4'd8, {1'b0, 7'd101}, 1'b0);
        send_byte(4'd10, hdr0(1'b1, OP_PING), 1'b1);     // oversize reported ahead of control
        send_byte(4'd10, {1'b1, LEN_EXT16}, 1'b0);
        send_byte(4'd10, 8'h00, 1'b0);
        send_byte(4'd10, 8'd126, 1'b0);
        run_random_traffic(300);
    endtask

    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = rx_burst ? 0 : $urandom_range(0, 19);
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_deframe_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (frame_results_q.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual conn %0d ev %0d",
                         $time, out_ch.out_conn, out_ch.event_res);
                mismatch_cnt++;
            end else begin
                want = frame_results_q.pop_front();
                compare_field("out_conn", 8'(want.conn), 8'(out_ch.out_conn));
                compare_field("event_res", 8'(want.ev), 8'(out_ch.event_res));
                compare_field("payload_byte", want.data, out_ch.payload_byte);
                compare_field("frame_opcode", 8'(want.opcode), 8'(out_ch.frame_opcode));
                compare_field("frame_fin", 8'(want.fin), 8'(out_ch.frame_fin));
                compare_field("is_control", 8'(want.ctrl), 8'(out_ch.is_control));
                compare_field("frame_last", 8'(want.last), 8'(out_ch.frame_last));
            end
        end
    end

    initial begin : watchdog
        int unsigned n;
        n = 0;
        while (n < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.conn_id      <= '0;
        in_ch.data_byte    <= '0;
        in_ch.packet_start <= 1'b0;
        reset_context();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        run_random_traffic(450);
        test_backpressure();
        test_zero_limit();
        test_full_limit();
        test_mid_limit();

        release_input();
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
rtl/core/wsd_pkg.sv
rtl/core/wsd_in_if.sv
rtl/core/wsd_out_if.sv
rtl/core/wsd_ram.sv
rtl/core/websocket_frame_deframer_top.sv
bench/websocket_frame_deframer_top_tb.sv
